// ----- src/aph2d_pkg.sv -----
`default_nettype none

package aph2d_pkg;

  localparam int ANGLE_BITS    = 13;
  localparam int WIDTH_BITS    = 13;
  localparam int READ_IDX_BITS = 6;
  localparam int OUT_BITS      = 20;

  localparam logic [WIDTH_BITS-1:0] BIN_WIDTH_RESET = 13'd160;

  // -180 degrees in 1/16 degree
  localparam int ANGLE_OFFSET = 2880;

  // Basin bounds on edge + ANGLE_OFFSET, i.e. on index * bin_width
  localparam int unsigned PHI_ZERO      = ANGLE_OFFSET;
  localparam int unsigned PHI_ALEFT_HI  = ANGLE_OFFSET + 1920;
  localparam int unsigned PSI_BETA_LO   = ANGLE_OFFSET + 1440;
  localparam int unsigned PSI_BETA_HI   = ANGLE_OFFSET + 2880;
  localparam int unsigned PSI_PASS_LO   = ANGLE_OFFSET + 480;
  localparam int unsigned PSI_ARIGHT_LO = ANGLE_OFFSET - 1920;
  localparam int unsigned PSI_ALEFT_LO  = ANGLE_OFFSET - 320;
  localparam int unsigned PSI_ALEFT_HI  = ANGLE_OFFSET + 1440;

  // one quotient bit per step
  localparam int DIV_STEPS = ANGLE_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- src/aph2d_in_if.sv -----
`default_nettype none

interface aph2d_in_if
  import aph2d_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic signed [ANGLE_BITS-1:0]    phi_angle;
  logic signed [ANGLE_BITS-1:0]    psi_angle;
  logic        [READ_IDX_BITS-1:0] read_bin_x;
  logic        [READ_IDX_BITS-1:0] read_bin_y;

  modport source (
    output valid, action, phi_angle, psi_angle, read_bin_x, read_bin_y,
    input  ready
  );

  modport sink (
    input  valid, action, phi_angle, psi_angle, read_bin_x, read_bin_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/aph2d_out_if.sv -----
`default_nettype none

interface aph2d_out_if
  import aph2d_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] bin_count;
  logic [OUT_BITS-1:0] peak_count;
  logic [OUT_BITS-1:0] sample_total;
  logic [OUT_BITS-1:0] beta_count;
  logic [OUT_BITS-1:0] pass_count;
  logic [OUT_BITS-1:0] alpha_right_count;
  logic [OUT_BITS-1:0] alpha_left_count;

  modport source (
    output valid, bin_count, peak_count, sample_total, beta_count, pass_count,
           alpha_right_count, alpha_left_count,
    input  ready
  );

  modport sink (
    input  valid, bin_count, peak_count, sample_total, beta_count, pass_count,
           alpha_right_count, alpha_left_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/angle_pair_histogram_2d_top.sv -----
// Two-dimensional histogram of (phi, psi) angle pairs.
// Input channel in_chan: an add beat bins phi and psi by bin_width and bumps
// one cell of the count memory; a read beat returns the count of one cell.
// Output channel out_chan: one result beat per input beat, carrying the cell
// count and the peak, total and four basin counters after that beat.
// cfg_wr_en / cfg_wr_data write bin_width (0 acts as 1); write only when idle.
// Sequence: an add runs the two 13-step serial dividers, then a memory read
// and the write-back; a read does the memory read, then the result. One item
// is in work at a time, so a new beat is accepted only after the last
// result is loaded.
// Reset: counters clear at once; the count memory is swept to zero one cell
// a cycle, all BINS_PER_AXIS^2 cells (4096 by default), and in_chan.ready
// stays low until the sweep is done.
// Stall: the result sits in an output register until taken; meanwhile one
// more beat is accepted and worked up to its write-back, where it waits.
`default_nettype none

module angle_pair_histogram_2d_top
  import aph2d_pkg::*;
#(
  parameter int BINS_PER_AXIS = 64,
  parameter int COUNT_BITS    = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [WIDTH_BITS-1:0] cfg_wr_data,
  aph2d_in_if.sink                   in_chan,
  aph2d_out_if.source                out_chan
);

  localparam int IDX_BITS  = $clog2(BINS_PER_AXIS);
  localparam int CELLS     = BINS_PER_AXIS * BINS_PER_AXIS;
  localparam int CELL_BITS = $clog2(CELLS);
  localparam int PROD_BITS = IDX_BITS + WIDTH_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(BINS_PER_AXIS - 1);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] shift_angle(input logic signed [ANGLE_BITS-1:0] a);
    logic signed [ANGLE_BITS:0] off;
    off = {a[ANGLE_BITS-1], a} + (ANGLE_BITS+1)'(ANGLE_OFFSET);
    // below -180 degrees lands in bin 0
    return off[ANGLE_BITS] ? '0 : off[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [IDX_BITS-1:0] clamp_idx(input logic [ANGLE_BITS-1:0] q);
    return (32'(q) > BINS_PER_AXIS - 1) ? IDX_LAST : IDX_BITS'(q);
  endfunction

  state_t state, state_next;

  logic [WIDTH_BITS-1:0] bin_width;
  logic [WIDTH_BITS-1:0] w_eff;
  logic [WIDTH_BITS-1:0] w_cur;
  logic                  act;
  logic                  rd_ok;
  logic [IDX_BITS-1:0]   ix, iy;
  logic [CELL_BITS-1:0]  cell_addr;
  logic [PROD_BITS-1:0]  px, py;

  logic [COUNT_BITS-1:0] peak, total, beta, pass, aright, aleft;

  logic                  out_valid;
  logic [OUT_BITS-1:0]   o_bin, o_peak, o_total, o_beta, o_pass, o_aright, o_aleft;

  // FSM outputs
  logic in_ready;
  logic div_start;
  logic mem_rd_en;
  logic fin_load;

  logic                  in_fire;
  logic                  done_x, done_y;
  logic [ANGLE_BITS-1:0] quo_x, quo_y;
  logic [IDX_BITS-1:0]   ix_c, iy_c;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  clr_busy;

  logic [COUNT_BITS-1:0] cnt_new, res_cnt;
  logic [COUNT_BITS-1:0] peak_next, total_next;
  logic [COUNT_BITS-1:0] beta_next, pass_next, aright_next, aleft_next;
  logic                  phi_low, in_beta, in_pass, in_aright, in_aleft;
  logic                  is_add;

  assign w_eff   = (bin_width == '0) ? WIDTH_BITS'(1) : bin_width;
  assign in_fire = in_chan.valid & in_ready;
  assign ix_c    = clamp_idx(quo_x);
  assign iy_c    = clamp_idx(quo_y);
  assign is_add  = (act == ACT_ADD);

  aph2d_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (shift_angle(in_chan.phi_angle)),
    .divisor  (w_eff),
    .done     (done_x),
    .quotient (quo_x)
  );

  aph2d_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (shift_angle(in_chan.psi_angle)),
    .divisor  (w_eff),
    .done     (done_y),
    .quotient (quo_y)
  );

  aph2d_mem #(
    .DEPTH     (CELLS),
    .ADDR_BITS (CELL_BITS),
    .DATA_BITS (COUNT_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (mem_rd_en),
    .rd_addr  (cell_addr),
    .rd_data  (rd_data),
    .wr_en    (fin_load & is_add),
    .wr_addr  (cell_addr),
    .wr_data  (cnt_new),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    mem_rd_en  = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = ~clr_busy;
        if (in_chan.valid && !clr_busy) begin
          if (in_chan.action == ACT_READ) begin
            state_next = ST_LOOK;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (done_x && done_y) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        mem_rd_en  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_chan.ready) begin
          fin_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act   <= in_chan.action;
      w_cur <= w_eff;
      rd_ok <= (32'(in_chan.read_bin_x) < BINS_PER_AXIS) &&
               (32'(in_chan.read_bin_y) < BINS_PER_AXIS);
      cell_addr <= CELL_BITS'(IDX_BITS'(in_chan.read_bin_x)) * CELL_BITS'(BINS_PER_AXIS)
                 + CELL_BITS'(IDX_BITS'(in_chan.read_bin_y));
    end else if (state == ST_DIV && done_x && done_y) begin
      ix        <= ix_c;
      iy        <= iy_c;
      cell_addr <= CELL_BITS'(ix_c) * CELL_BITS'(BINS_PER_AXIS) + CELL_BITS'(iy_c);
    end
    if (mem_rd_en) begin
      px <= PROD_BITS'(ix) * PROD_BITS'(w_cur);
      py <= PROD_BITS'(iy) * PROD_BITS'(w_cur);
    end
  end

  // basins judged on lower bin edges, offset by +180 degrees
  always_comb begin
    phi_low   = 32'(px) <= PHI_ZERO;
    in_beta   = phi_low && 32'(py) >= PSI_BETA_LO && 32'(py) <= PSI_BETA_HI;
    in_pass   = phi_low && 32'(py) >= PSI_PASS_LO && 32'(py) < PSI_BETA_LO;
    in_aright = phi_low && 32'(py) >= PSI_ARIGHT_LO && 32'(py) < PSI_PASS_LO;
    in_aleft  = !phi_low && 32'(px) <= PHI_ALEFT_HI &&
                32'(py) >= PSI_ALEFT_LO && 32'(py) <= PSI_ALEFT_HI;

    cnt_new = sat_inc(rd_data);
    if (is_add) begin
      res_cnt = cnt_new;
    end else begin
      res_cnt = rd_ok ? rd_data : '0;
    end

    peak_next   = peak;
    total_next  = total;
    beta_next   = beta;
    pass_next   = pass;
    aright_next = aright;
    aleft_next  = aleft;
    if (is_add) begin
      if (cnt_new > peak) begin
        peak_next = cnt_new;
      end
      total_next = sat_inc(total);
      if (in_beta) begin
        beta_next = sat_inc(beta);
      end
      if (in_pass) begin
        pass_next = sat_inc(pass);
      end
      if (in_aright) begin
        aright_next = sat_inc(aright);
      end
      if (in_aleft) begin
        aleft_next = sat_inc(aleft);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= BIN_WIDTH_RESET;
      peak      <= '0;
      total     <= '0;
      beta      <= '0;
      pass      <= '0;
      aright    <= '0;
      aleft     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bin_width <= cfg_wr_data;
      end
      if (fin_load) begin
        peak      <= peak_next;
        total     <= total_next;
        beta      <= beta_next;
        pass      <= pass_next;
        aright    <= aright_next;
        aleft     <= aleft_next;
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      o_bin    <= OUT_BITS'(res_cnt);
      o_peak   <= OUT_BITS'(peak_next);
      o_total  <= OUT_BITS'(total_next);
      o_beta   <= OUT_BITS'(beta_next);
      o_pass   <= OUT_BITS'(pass_next);
      o_aright <= OUT_BITS'(aright_next);
      o_aleft  <= OUT_BITS'(aleft_next);
    end
  end

  assign in_chan.ready              = in_ready;
  assign out_chan.valid             = out_valid;
  assign out_chan.bin_count         = o_bin;
  assign out_chan.peak_count        = o_peak;
  assign out_chan.sample_total      = o_total;
  assign out_chan.beta_count        = o_beta;
  assign out_chan.pass_count        = o_pass;
  assign out_chan.alpha_right_count = o_aright;
  assign out_chan.alpha_left_count  = o_aleft;

endmodule

`default_nettype wire

// ----- src/aph2d_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module aph2d_div
  import aph2d_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ANGLE_BITS-1:0] dividend,
  input  wire logic [WIDTH_BITS-1:0] divisor,
  output logic                       done,
  output logic      [ANGLE_BITS-1:0] quotient
);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [WIDTH_BITS-1:0] dvs;
  logic [WIDTH_BITS-1:0] rem;
  logic [ANGLE_BITS-1:0] quo;

  logic [WIDTH_BITS:0]   rem_sh;
  logic                  take;
  logic [WIDTH_BITS-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quo[ANGLE_BITS-1]};
    take     = rem_sh >= {1'b0, dvs};
    // rem < dvs keeps both results within WIDTH_BITS
    rem_next = take ? WIDTH_BITS'(rem_sh - {1'b0, dvs}) : WIDTH_BITS'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[ANGLE_BITS-2:0], take};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ----- src/aph2d_mem.sv -----
`default_nettype none

// Count memory: one read and one write port, registered read data,
// swept to zero after reset.
module aph2d_mem #(
  parameter int DEPTH     = 4096,
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  output logic                      clr_busy
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;

  logic                 we;
  logic [ADDR_BITS-1:0] wa;
  logic [DATA_BITS-1:0] wd;

  always_comb begin
    we = clr_busy | wr_en;
    wa = clr_busy ? clr_addr : wr_addr;
    wd = clr_busy ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_BITS'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
